/* rtl/pms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants of the periodic message scheduler
// Field widths, parameter defaults, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int DEF_NUM_CHANNELS = 10;
  localparam int DEF_OFF_RETRY_MS = 1200;

  localparam int TIME_W = 16;  // elapsed, period, deadline and sleep time
  localparam int CHAN_W = 4;   // channel field of a write item
  localparam int FIRE_W = 10;  // fire mask

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Item kinds carried in the input tuser bit.
  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_WRITE   = 1'b1
  } pms_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } pms_state_t;

  typedef struct packed {
    logic load;     // capture the accepted item, write the period table
    logic step;     // process the channel under the walk counter
    logic publish;  // move mask and minimum into the output register
  } pms_cmd_t;

  typedef struct packed {
    logic last;     // the walk counter points at the final channel
  } pms_sts_t;

endpackage

/* rtl/pms_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_ctrl: sequencing controller of the periodic message scheduler
// Accepts an item, steps the datapath over every channel and hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
module pms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output pms_pkg::pms_cmd_t cmd,
  input  pms_pkg::pms_sts_t sts
);
  import pms_pkg::*;

  pms_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An accepted item always starts a walk.
  a_load_walks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_WALK)
    else $error("accepted item did not start a walk");

  // A result is never published over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_tready))
    else $error("result published over a pending result");

  // Publishing always leaves a valid result behind.
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result not presented");

endmodule

/* rtl/pms_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_dp: datapath of the periodic message scheduler
// Holds the deadline and period tables, walks them one channel a cycle with
// a saturating subtract, reload and running minimum, and keeps the result.
// ----------------------------------------------------------------------------
module pms_dp #(
  parameter int NUM_CHANNELS = pms_pkg::DEF_NUM_CHANNELS,
  parameter int OFF_RETRY_MS = pms_pkg::DEF_OFF_RETRY_MS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pms_pkg::pms_cmd_t           cmd,
  output pms_pkg::pms_sts_t           sts,
  input  logic                        in_kind,
  input  logic [pms_pkg::TIME_W-1:0]  in_elapsed_ms,
  input  logic [pms_pkg::CHAN_W-1:0]  in_channel,
  input  logic [pms_pkg::TIME_W-1:0]  in_period_ms,
  input  logic                        in_link_ready,
  output logic [pms_pkg::FIRE_W-1:0]  out_fire_mask,
  output logic [pms_pkg::TIME_W-1:0]  out_next_sleep_ms
);
  import pms_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);
  // Two bits above the channel field so that a count of 32 still fits.
  localparam logic [CHAN_W+1:0] NUM_CH_EXT = (CHAN_W + 2)'(NUM_CHANNELS);
  localparam logic [TIME_W-1:0] OFF_RETRY = TIME_W'(OFF_RETRY_MS);

  logic [TIME_W-1:0] deadline_r [NUM_CHANNELS];
  logic [TIME_W-1:0] period_r   [NUM_CHANNELS];

  logic [IDX_W-1:0]  idx_r;
  logic              kind_r;
  logic              link_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [FIRE_W-1:0] mask_r, mask_nxt;
  logic [TIME_W-1:0] min_r, min_nxt;
  logic [FIRE_W-1:0] out_mask_r;
  logic [TIME_W-1:0] out_sleep_r;

  logic              chan_ok;
  logic [IDX_W-1:0]  wr_idx;
  logic [TIME_W-1:0] d_cur, p_cur, d_sub, d_new;
  logic              due, fire;

  assign chan_ok  = {2'b00, in_channel} < NUM_CH_EXT;
  assign wr_idx   = IDX_W'(in_channel);
  assign sts.last = (idx_r == LAST_IDX);

  assign d_cur = deadline_r[idx_r];
  assign p_cur = period_r[idx_r];
  assign d_sub = (d_cur > elapsed_r) ? (d_cur - elapsed_r) : '0;
  // Zero or below after the subtraction counts as due.
  assign due   = (kind_r == KIND_ADVANCE) && (d_sub == '0);
  assign fire  = due && (p_cur != '0) && link_r;

  always_comb begin
    if (kind_r == KIND_WRITE) begin
      d_new = d_cur;
    end else if (due) begin
      d_new = (p_cur != '0) ? p_cur : OFF_RETRY;
    end else begin
      d_new = d_sub;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    for (int b = 0; b < FIRE_W; b++) begin
      if (fire && (int'(idx_r) == b)) begin
        mask_nxt[b] = 1'b1;
      end
    end
    if (idx_r == '0 || d_new < min_r) begin
      min_nxt = d_new;
    end else begin
      min_nxt = min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        deadline_r[i] <= '0;
        period_r[i]   <= '0;
      end
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        if (in_kind == KIND_WRITE && chan_ok) begin
          period_r[wr_idx] <= in_period_ms;
        end
      end
      if (cmd.step) begin
        deadline_r[idx_r] <= d_new;
        idx_r             <= sts.last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      link_r    <= in_link_ready;
      elapsed_r <= in_elapsed_ms;
      mask_r    <= '0;
    end
    if (cmd.step) begin
      mask_r <= mask_nxt;
      min_r  <= min_nxt;
    end
    if (cmd.publish) begin
      out_mask_r  <= mask_r;
      out_sleep_r <= min_r;
    end
  end

  assign out_fire_mask     = out_mask_r;
  assign out_next_sleep_ms = out_sleep_r;

  // After an advance every deadline is reloaded or still counting down.
  a_deadline_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && kind_r == KIND_ADVANCE) |-> d_new != '0)
    else $error("deadline left at zero after an advance");

  // A write item never fires a channel.
  a_write_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.publish && kind_r == KIND_WRITE) |=> out_fire_mask == '0)
    else $error("fire bit set by a write item");

  // The walk counter never points past the final channel.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("walk counter beyond the final channel");

endmodule

/* rtl/periodic_message_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_message_scheduler_unit: multi-channel periodic deadline scheduler
// Keeps a countdown deadline and a send period per channel, advances them on
// request and reports which channels must send and how long to sleep next.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer carries
//  -------  ---------  -----------------------------------------------------
//  in_      slave      one advance item or one period write item
//  out_     master     fire mask and next sleep time, one per input item
//
// Every input item is handled in order: the block accepts it, walks channel by
// channel through the deadline and period tables, which share a single
// subtract, reload and minimum unit, and then loads the output register. The
// block accepts the next item while a result still waits in the output
// register; it stalls only at the end of a walk when that register is still
// full. Reset is synchronous and active low; it clears every deadline and
// switches every channel off.
//
module periodic_message_scheduler_unit #(
  parameter int NUM_CHANNELS = pms_pkg::DEF_NUM_CHANNELS,
  parameter int OFF_RETRY_MS = pms_pkg::DEF_OFF_RETRY_MS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: elapsed_ms[15:0], channel[19:16], period_ms[35:20],
  // link_ready[36], zero padding[39:37].
  input  logic [pms_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: kind (0 = advance, 1 = write period).
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: fire_mask[9:0], next_sleep_ms[25:10],
  // zero padding[31:26].
  output logic [pms_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pms_pkg::*;

  pms_cmd_t          cmd;
  pms_sts_t          sts;
  logic [FIRE_W-1:0] fire_mask;
  logic [TIME_W-1:0] next_sleep_ms;

  // Sequencing: accepts a transfer, steps the walk and publishes the result.
  pms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Tables, per-channel arithmetic and the output register.
  pms_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .OFF_RETRY_MS (OFF_RETRY_MS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_tuser),
    .in_elapsed_ms     (in_tdata[15:0]),
    .in_channel        (in_tdata[19:16]),
    .in_period_ms      (in_tdata[35:20]),
    .in_link_ready     (in_tdata[36]),
    .out_fire_mask     (fire_mask),
    .out_next_sleep_ms (next_sleep_ms)
  );

  // Bits 39:37 of in_tdata are padding and are not used.
  assign out_tdata = {(OUT_DATA_W - FIRE_W - TIME_W)'(0), next_sleep_ms, fire_mask};

endmodule
